[rtl/fsim_pkg.sv]
// fsim_pkg: shared constants, codes, beat types and helpers of the sector-id mapper
// no dependencies; imported by the interfaces, fsim_core and floppy_sector_id_mapper

package fsim_pkg;

    // image layout
    localparam int NUM_DRIVES        = 4;
    localparam int LAST_TRACK        = 153;
    localparam int SECTORS_PER_TRACK = 8;
    localparam int SECTOR_SHIFT      = 10;
    localparam int SIZE_CODE         = 3;
    localparam int FMT_COUNT_MAX     = SECTORS_PER_TRACK + 1;

    // field widths
    localparam int OP_W     = 3;
    localparam int DRIVE_W  = 2;
    localparam int TRACK_W  = 8;
    localparam int BYTE_W   = 8;
    localparam int SECT_W   = $clog2(SECTORS_PER_TRACK);
    localparam int CYL_W    = 7;
    localparam int REC_W    = 4;
    localparam int SIZE_W   = 3;
    localparam int OFFSET_W = 21;
    localparam int FMTC_W   = 4;
    localparam int IDSUM_W  = BYTE_W + 2;

    // configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_DRIVE_LOADED = 1'b0;

    // operation codes
    localparam logic [OP_W-1:0] OP_SEEK     = 3'd0;
    localparam logic [OP_W-1:0] OP_CUR_ID   = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_ID  = 3'd2;
    localparam logic [OP_W-1:0] OP_FORMAT   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ     = 3'd4;
    localparam logic [OP_W-1:0] OP_DIAG     = 3'd5;
    localparam logic [OP_W-1:0] OP_WRITE    = 3'd6;

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [DRIVE_W-1:0] drive;
        logic [TRACK_W-1:0] track;
        logic [BYTE_W-1:0]  id_cyl;
        logic [BYTE_W-1:0]  id_head;
        logic [BYTE_W-1:0]  id_rec;
        logic [BYTE_W-1:0]  id_size;
        logic               entry_last;
    } t_item;

    typedef struct packed {
        logic                status;
        logic [CYL_W-1:0]    out_cyl;
        logic                out_head;
        logic [REC_W-1:0]    out_rec;
        logic [SIZE_W-1:0]   out_size;
        logic [OFFSET_W-1:0] byte_offset;
    } t_result;

    // control from the top level to the core
    typedef struct packed {
        logic                  fire;
        logic [NUM_DRIVES-1:0] drive_loaded;
    } t_core_ctl;

    // what the core makes of the current item
    typedef struct packed {
        logic    has_result;
        t_result res;
    } t_core_res;

    // image offset of a sector, wrapped to the offset width
    function automatic logic [OFFSET_W-1:0] calc_offset(logic [TRACK_W-1:0] trk,
                                                       logic [SECT_W-1:0] sec);
        logic [31:0] full;
        full = 32'({trk, sec}) << SECTOR_SHIFT;
        return full[OFFSET_W-1:0];
    endfunction

endpackage

[rtl/fsim_item_if.sv]
// fsim_item_if: valid/ready channel carrying one command beat
// depends on fsim_pkg for field widths

interface fsim_item_if import fsim_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [DRIVE_W-1:0] drive;
    logic [TRACK_W-1:0] track;
    logic [BYTE_W-1:0]  id_cyl;
    logic [BYTE_W-1:0]  id_head;
    logic [BYTE_W-1:0]  id_rec;
    logic [BYTE_W-1:0]  id_size;
    logic               entry_last;

    modport source (
        output valid, op, drive, track, id_cyl, id_head, id_rec, id_size, entry_last,
        input  ready
    );
    modport sink (
        input  valid, op, drive, track, id_cyl, id_head, id_rec, id_size, entry_last,
        output ready
    );
endinterface

[rtl/fsim_res_if.sv]
// fsim_res_if: valid/ready channel carrying one result beat
// depends on fsim_pkg for field widths

interface fsim_res_if import fsim_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                status;
    logic [CYL_W-1:0]    out_cyl;
    logic                out_head;
    logic [REC_W-1:0]    out_rec;
    logic [SIZE_W-1:0]   out_size;
    logic [OFFSET_W-1:0] byte_offset;

    modport source (
        output valid, status, out_cyl, out_head, out_rec, out_size, byte_offset,
        input  ready
    );
    modport sink (
        input  valid, status, out_cyl, out_head, out_rec, out_size, byte_offset,
        output ready
    );
endinterface

[rtl/fsim_core.sv]
// fsim_core: per-drive track and sector counter state, format list tracking,
// id checks and offset calculation for one registered command; uses fsim_pkg

module fsim_core import fsim_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    input  t_item     i_item,
    output t_core_res o_res
);

    logic [TRACK_W-1:0] r_track_pos  [NUM_DRIVES];
    logic [SECT_W-1:0]  r_sector_cnt [NUM_DRIVES];
    logic [FMTC_W-1:0]  r_fmt_count;
    logic               r_fmt_error;

    logic [FMTC_W-1:0]  n_fmt_count;
    logic               n_fmt_error;
    logic               n_trk_we;
    logic [TRACK_W-1:0] n_trk;
    logic               n_cnt_we;
    logic [SECT_W-1:0]  n_cnt;

    logic [TRACK_W-1:0] cur_trk;
    logic [SECT_W-1:0]  cnt;
    logic [SECT_W-1:0]  seek_cnt;
    logic [SECT_W-1:0]  rec_idx;
    logic               usable;
    logic               cur_ok;
    logic               trk_ok;
    logic [IDSUM_W-1:0] id_sum;
    logic               match_in;
    logic               match_cur;
    logic               rec_ok;
    logic               size_ok;
    logic               fmt_bad;
    logic [FMTC_W-1:0]  fmt_inc;

    assign cur_trk   = r_track_pos[i_item.drive];
    assign cnt       = r_sector_cnt[i_item.drive];
    assign usable    = ({1'b0, i_item.drive} < (DRIVE_W+1)'(NUM_DRIVES))
                       && i_ctl.drive_loaded[i_item.drive];
    assign cur_ok    = cur_trk <= TRACK_W'(LAST_TRACK);
    assign trk_ok    = i_item.track <= TRACK_W'(LAST_TRACK);
    assign id_sum    = {1'b0, i_item.id_cyl, 1'b0} + {2'b00, i_item.id_head};
    assign match_in  = id_sum == {2'b00, i_item.track};
    assign match_cur = id_sum == {2'b00, cur_trk};
    assign rec_ok    = (i_item.id_rec >= 8'd1) && (i_item.id_rec <= BYTE_W'(SECTORS_PER_TRACK));
    assign size_ok   = i_item.id_size == BYTE_W'(SIZE_CODE);
    assign fmt_bad   = !usable || !trk_ok || !match_in || !rec_ok || !size_ok;
    assign fmt_inc   = (r_fmt_count <= FMTC_W'(SECTORS_PER_TRACK)) ?
                       r_fmt_count + FMTC_W'(1) : r_fmt_count;
    assign seek_cnt  = (cur_trk != i_item.track) ? '0 : cnt;
    assign rec_idx   = i_item.id_rec[SECT_W-1:0] - SECT_W'(1);

    always_comb begin
        o_res.has_result = 1'b1;
        o_res.res        = '0;
        o_res.res.status = ST_REJECT;
        n_fmt_count      = r_fmt_count;
        n_fmt_error      = r_fmt_error;
        n_trk_we         = 1'b0;
        n_trk            = i_item.track;
        n_cnt_we         = 1'b0;
        n_cnt            = cnt;
        case (i_item.op)
            OP_SEEK: begin
                if (usable && trk_ok) begin
                    n_trk_we               = 1'b1;
                    n_cnt_we               = 1'b1;
                    n_cnt                  = seek_cnt;
                    o_res.res.status       = ST_OK;
                    o_res.res.out_cyl      = i_item.track[TRACK_W-1:1];
                    o_res.res.out_head     = i_item.track[0];
                    o_res.res.out_rec      = REC_W'(seek_cnt) + REC_W'(1);
                    o_res.res.out_size     = SIZE_W'(SIZE_CODE);
                end
            end
            OP_CUR_ID, OP_READ_ID, OP_DIAG: begin
                if (usable && cur_ok) begin
                    o_res.res.status       = ST_OK;
                    o_res.res.out_cyl      = cur_trk[TRACK_W-1:1];
                    o_res.res.out_head     = cur_trk[0];
                    o_res.res.out_rec      = REC_W'(cnt) + REC_W'(1);
                    o_res.res.out_size     = SIZE_W'(SIZE_CODE);
                    if (i_item.op == OP_DIAG) begin
                        o_res.res.byte_offset = calc_offset(cur_trk, cnt);
                    end
                    if (i_item.op != OP_CUR_ID) begin
                        n_cnt_we = 1'b1;
                        n_cnt    = cnt + SECT_W'(1);
                    end
                end
            end
            OP_READ, OP_WRITE: begin
                if (usable && cur_ok && match_cur && rec_ok && (i_item.id_head <= 8'd1)
                    && size_ok) begin
                    o_res.res.status      = ST_OK;
                    o_res.res.out_cyl     = cur_trk[TRACK_W-1:1];
                    o_res.res.out_head    = cur_trk[0];
                    o_res.res.out_rec     = i_item.id_rec[REC_W-1:0];
                    o_res.res.out_size    = SIZE_W'(SIZE_CODE);
                    o_res.res.byte_offset = calc_offset(cur_trk, rec_idx);
                    n_cnt_we              = 1'b1;
                    n_cnt                 = i_item.id_rec[SECT_W-1:0];
                end
            end
            OP_FORMAT: begin
                n_fmt_count = fmt_inc;
                n_fmt_error = r_fmt_error | fmt_bad;
                if (!i_item.entry_last) begin
                    o_res.has_result = 1'b0;
                end else begin
                    if (!n_fmt_error && (fmt_inc == FMTC_W'(SECTORS_PER_TRACK))) begin
                        n_trk_we         = 1'b1;
                        o_res.res.status = ST_OK;
                    end
                    n_fmt_count = '0;
                    n_fmt_error = 1'b0;
                end
            end
            default: begin
                o_res.res.status = ST_REJECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DRIVES; d++) begin
                r_track_pos[d]  <= '0;
                r_sector_cnt[d] <= '0;
            end
            r_fmt_count <= '0;
            r_fmt_error <= 1'b0;
        end else if (i_ctl.fire) begin
            if (n_trk_we) begin
                r_track_pos[i_item.drive] <= n_trk;
            end
            if (n_cnt_we) begin
                r_sector_cnt[i_item.drive] <= n_cnt;
            end
            r_fmt_count <= n_fmt_count;
            r_fmt_error <= n_fmt_error;
        end
    end

    // format count saturates one past a full track
    a_fmt_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fmt_count <= FMTC_W'(FMT_COUNT_MAX))
        else $error("format count beyond saturation");

    // an accepted seek leaves the drive on the requested track
    a_seek_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fire && (i_item.op == OP_SEEK) && (o_res.res.status == ST_OK))
        |=> r_track_pos[$past(i_item.drive)] == $past(i_item.track))
        else $error("seek did not update track position");

endmodule

[rtl/floppy_sector_id_mapper.sv]
// floppy_sector_id_mapper: top level of the sector-id mapper for a four-drive bank
// depends on fsim_pkg, fsim_item_if, fsim_res_if and fsim_core
//
//  channel   dir  handshake          beat
//  i_item    in   valid/ready        op, drive, track, id_cyl/head/rec/size, entry_last
//  o_res     out  valid/ready        status, out_cyl/head/rec/size, byte_offset
//  apb       in   psel/penable/pwrite  drive_loaded at byte addresses 0 to 3, pready tied high
//
//  one command per cycle sustained while the result channel is ready; each command beat
//  passes the input register, then the result register behind the core's single-pass logic
//  a format entry that is not the last of its list gives no result beat
//  reset is synchronous, active low, and clears drive state, format tracking and valids
//  a stalled result holds the result register; the input register still moves while
//  the result register is empty or being taken, so ready only drops on a real stall

module floppy_sector_id_mapper import fsim_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // command and result channels
    fsim_item_if.sink          i_item,
    fsim_res_if.source         o_res
);

    logic [NUM_DRIVES-1:0] r_drive_loaded;
    logic                  r_in_valid;
    t_item                 r_in;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  advance;
    logic                  in_take;
    logic                  cfg_wr;
    logic                  reg_sel;
    t_core_ctl             core_ctl;
    t_core_res             core_res;

    // ---- configuration register ----
    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1] == REG_DRIVE_LOADED;
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? PDATA_W'(r_drive_loaded) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_loaded <= '0;
        end else if (cfg_wr) begin
            r_drive_loaded <= pwdata[NUM_DRIVES-1:0];
        end
    end

    // ---- pipeline control ----
    // the held command goes through the core when the result register can take it
    assign advance      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign in_take      = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && core_res.has_result) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.op         <= i_item.op;
            r_in.drive      <= i_item.drive;
            r_in.track      <= i_item.track;
            r_in.id_cyl     <= i_item.id_cyl;
            r_in.id_head    <= i_item.id_head;
            r_in.id_rec     <= i_item.id_rec;
            r_in.id_size    <= i_item.id_size;
            r_in.entry_last <= i_item.entry_last;
        end
        if (advance && core_res.has_result) begin
            r_out <= core_res.res;
        end
    end

    // ---- id checks and drive state ----
    assign core_ctl.fire         = advance;
    assign core_ctl.drive_loaded = r_drive_loaded;

    fsim_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_item  (r_in),
        .o_res   (core_res)
    );

    // ---- result channel ----
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.out_cyl     = r_out.out_cyl;
    assign o_res.out_head    = r_out.out_head;
    assign o_res.out_rec     = r_out.out_rec;
    assign o_res.out_size    = r_out.out_size;
    assign o_res.byte_offset = r_out.byte_offset;

    // a command that yields a result is presented on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && core_res.has_result) |=> r_out_valid)
        else $error("result beat lost behind the core");

    // a rejected beat carries nothing but its status
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_REJECT)) |->
        ((r_out.out_cyl == '0) && !r_out.out_head && (r_out.out_rec == '0)
         && (r_out.out_size == '0) && (r_out.byte_offset == '0)))
        else $error("rejected result has non-zero fields");

endmodule
